// ===== rtl/core/okl_pkg.sv =====
// ----------------------------------------------------------------------------
// okl_pkg: shared types and codes for the ordered key list
// Beat layouts of the request and response channels, status and mode codes,
// and the control word that the sequencer broadcasts to the slot cells.
// ----------------------------------------------------------------------------
`default_nettype none

package okl_pkg;

   localparam int KEY_W     = 64;
   localparam int MAX_LIST  = 16;   // a listing emits at most this many beats

   // request modes
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_LIST   = 2'd2;

   // response status codes
   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_REMOVED   = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_ENTRY     = 3'd4;
   localparam logic [2:0] ST_EMPTY     = 3'd5;

   // cell operations
   localparam logic [2:0] CELL_HOLD    = 3'd0;
   localparam logic [2:0] CELL_WRITE   = 3'd1;
   localparam logic [2:0] CELL_COMPARE = 3'd2;
   localparam logic [2:0] CELL_REMOVE  = 3'd3;
   localparam logic [2:0] CELL_ROTATE  = 3'd4;

   typedef struct packed {
      logic [1:0]       mode;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [KEY_W-1:0] entry_key;
      logic [3:0]       position;
      logic [4:0]       entry_count;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]       op;
      logic [KEY_W-1:0] key;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/okl_cell.sv =====
// ----------------------------------------------------------------------------
// okl_cell: one slot of the ordered key list
// Holds one key. Writes at the tail, compares against a broadcast key,
// and shifts from its right neighbor on remove or rotate.
// ----------------------------------------------------------------------------
`default_nettype none

module okl_cell #(
   parameter int CNT_W = 5,
   parameter int INDEX = 0
) (
   input  wire                         clock,
   input  okl_pkg::cell_ctl_type       ctl,
   input  wire  [CNT_W-1:0]            count,
   input  wire  [okl_pkg::KEY_W-1:0]   next_key,
   input  wire  [okl_pkg::KEY_W-1:0]   head_key,
   input  wire                         seen_in,
   output logic [okl_pkg::KEY_W-1:0]   key_out,
   output logic                        seen_out,
   output logic                        hit
);

   localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(INDEX + 1);

   logic [okl_pkg::KEY_W-1:0] key_ff, key_in;
   logic                      hit_ff, hit_in;

   always_comb begin
      key_in = key_ff;
      hit_in = hit_ff;
      unique case (ctl.op)
         okl_pkg::CELL_WRITE: begin
            if (count == MY_IDX) key_in = ctl.key;
         end
         okl_pkg::CELL_COMPARE: begin
            hit_in = (MY_IDX < count) && (key_ff == ctl.key);
         end
         okl_pkg::CELL_REMOVE: begin
            // at and past the first match, pull from the right
            if (seen_out) key_in = next_key;
         end
         okl_pkg::CELL_ROTATE: begin
            // tail slot wraps around to the head
            key_in = (count == MY_NEXT) ? head_key : next_key;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      hit_ff <= hit_in;
   end

   assign key_out  = key_ff;
   assign hit      = hit_ff;
   assign seen_out = seen_in | hit_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ordered_key_list_insert_remove.sv =====
// ----------------------------------------------------------------------------
// ordered_key_list_insert_remove: fixed-capacity ordered key list
// Row of slot cells plus a small sequencer for insert, remove and list.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_data and raise start; the beat is taken on a rising
//   edge with start high and busy low. Mode insert appends at the tail,
//   remove deletes the first equal key and closes the gap, list streams
//   the stored keys in slot order.
//   Response: each result shows on rsp_data for one cycle with rsp_valid
//   high; the receiver has to take it then, there is no back-pressure.
//   The final result of a request carries last.
// Timing:
//   Insert: result the cycle after acceptance; busy stays low.
//   Remove: a compare step checks all slots in parallel, then a compact
//   step closes the gap if a key matched; the result follows the compact step.
//   List: the row rotates once through all fill_count slots, one result
//   per cycle for the first 16 entries. An empty list answers with one
//   empty result the cycle after acceptance.
// Reset: clears the fill count and the sequencer; slot contents are not
// cleared and are never read before written.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_key_list_insert_remove #(
   parameter int CAPACITY  = 16,
   parameter int KEY_CHARS = 8
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  okl_pkg::req_type  req_data,
   output logic              rsp_valid,
   output okl_pkg::rsp_type  rsp_data
);

   localparam int KW    = okl_pkg::KEY_W;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);
   localparam logic [KW-1:0] KEY_MASK = {KW{1'b1}} << (8 * (8 - KEY_CHARS));

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MATCH = 2'd1;
   localparam logic [1:0] S_LIST  = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [KW-1:0]          key_ff, key_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   okl_pkg::rsp_type       rsp_ff, rsp_in;

   okl_pkg::cell_ctl_type  ctl;
   logic [KW-1:0]          chain_key [CAPACITY+1];
   logic [CAPACITY:0]      seen;
   logic [CAPACITY-1:0]    hit;

   logic                   accept;
   logic [KW-1:0]          req_key;
   logic [CNT_W-1:0]       count_inc, count_dec, idx_inc;
   logic [6:0]             hit_pos;
   logic [6:0]             idx_wide, count_wide, last_idx;

   // ---- slot row ----
   assign chain_key[CAPACITY] = '0;
   assign seen[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      okl_cell #(
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .count    (count_ff),
         .next_key (chain_key[i+1]),
         .head_key (chain_key[0]),
         .seen_in  (seen[i]),
         .key_out  (chain_key[i]),
         .seen_out (seen[i+1]),
         .hit      (hit[i])
      );
   end

   // first matching slot
   always_comb begin
      hit_pos = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (hit[i]) hit_pos = 7'(i);
      end
   end

   assign accept     = start && !busy;
   assign req_key    = req_data.key & KEY_MASK;
   assign count_inc  = count_ff + CNT_W'(1);
   assign count_dec  = count_ff - CNT_W'(1);
   assign idx_inc    = idx_ff + CNT_W'(1);
   assign idx_wide   = 7'(idx_ff);
   assign count_wide = 7'(count_ff);
   assign last_idx   = (count_wide > 7'(okl_pkg::MAX_LIST)) ?
                       7'(okl_pkg::MAX_LIST - 1) : count_wide - 7'd1;

   // ---- sequencer ----
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      key_in       = key_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ctl.op       = okl_pkg::CELL_HOLD;
      ctl.key      = req_key;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in = req_key;
               unique case (req_data.mode)
                  okl_pkg::MODE_INSERT: begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.entry_key   = req_key;
                     rsp_in.last        = 1'b1;
                     if (count_ff == CNT_CAP) begin
                        rsp_in.status      = okl_pkg::ST_FULL;
                        rsp_in.position    = '0;
                        rsp_in.entry_count = 5'(count_ff);
                     end else begin
                        ctl.op             = okl_pkg::CELL_WRITE;
                        count_in           = count_inc;
                        rsp_in.status      = okl_pkg::ST_INSERTED;
                        rsp_in.position    = 4'(count_ff);
                        rsp_in.entry_count = 5'(count_inc);
                     end
                  end
                  okl_pkg::MODE_REMOVE: begin
                     ctl.op   = okl_pkg::CELL_COMPARE;
                     state_in = S_MATCH;
                  end
                  okl_pkg::MODE_LIST: begin
                     if (count_ff == '0) begin
                        rsp_valid_in       = 1'b1;
                        rsp_in.status      = okl_pkg::ST_EMPTY;
                        rsp_in.entry_key   = req_key;
                        rsp_in.position    = '0;
                        rsp_in.entry_count = '0;
                        rsp_in.last        = 1'b1;
                     end else begin
                        idx_in   = '0;
                        state_in = S_LIST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MATCH: begin
            rsp_valid_in     = 1'b1;
            rsp_in.entry_key = key_ff;
            rsp_in.last      = 1'b1;
            state_in         = S_IDLE;
            if (seen[CAPACITY]) begin
               ctl.op             = okl_pkg::CELL_REMOVE;
               count_in           = count_dec;
               rsp_in.status      = okl_pkg::ST_REMOVED;
               rsp_in.position    = 4'(hit_pos);
               rsp_in.entry_count = 5'(count_dec);
            end else begin
               rsp_in.status      = okl_pkg::ST_NOT_FOUND;
               rsp_in.position    = '0;
               rsp_in.entry_count = 5'(count_ff);
            end
         end
         S_LIST: begin
            // head slot is read while the row rotates left by one
            ctl.op = okl_pkg::CELL_ROTATE;
            if (idx_wide < 7'(okl_pkg::MAX_LIST)) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = okl_pkg::ST_ENTRY;
               rsp_in.entry_key   = chain_key[0];
               rsp_in.position    = 4'(idx_ff);
               rsp_in.entry_count = 5'(count_ff);
               rsp_in.last        = (idx_wide == last_idx);
            end
            idx_in = idx_inc;
            if (idx_inc == count_ff) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
